>>> src/ihds_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and lookup functions for the image header sniffer.
// No dependencies; ihds_ctrl, ihds_out and the top level use this package by scoped names.
package ihds_pkg;

    // Scan window for frame markers, counted in bytes after the start pair
    localparam int SCAN_LIMIT     = 65536;
    // Offset counter stops here; it always covers the PNG header
    localparam int OFFSET_CAP     = (SCAN_LIMIT + 2 > 24) ? SCAN_LIMIT + 2 : 24;
    localparam int OFFSET_W       = $clog2(OFFSET_CAP + 1);
    // Byte cells in the shift chain (old window minus its oldest byte)
    localparam int WINDOW_CELLS   = 8;

    localparam int PNG_SIG_LEN    = 8;
    localparam int JPEG_START_LEN = 3;
    localparam int PNG_REPORT_POS = 23;
    localparam int JPEG_FIRST_POS = 10;
    localparam int JPEG_LAST_POS  = SCAN_LIMIT + 1;

    // JPEG marker bytes
    localparam logic [7:0] MARK_PREFIX = 8'hFF;
    localparam logic [7:0] MARK_SOF0   = 8'hC0;
    localparam logic [7:0] MARK_SOF1   = 8'hC1;
    localparam logic [7:0] MARK_SOF2   = 8'hC2;

    typedef logic [OFFSET_W-1:0] t_offset;
    typedef logic [WINDOW_CELLS-1:0][7:0] t_window;

    typedef enum logic [1:0] {
        KIND_UNKNOWN = 2'd0,
        KIND_PNG     = 2'd1,
        KIND_JPEG    = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] width;
        logic [31:0] height;
    } t_result;

    typedef struct packed {
        t_offset offset;
        logic    reported;
    } t_status;

    // PNG file signature, byte by byte
    function automatic logic [7:0] png_sig_byte(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0:    v = 8'h89;
            3'd1:    v = 8'h50;
            3'd2:    v = 8'h4E;
            3'd3:    v = 8'h47;
            3'd4:    v = 8'h0D;
            3'd5:    v = 8'h0A;
            3'd6:    v = 8'h1A;
            default: v = 8'h0A;
        endcase
        return v;
    endfunction

    // JPEG start: SOI marker followed by the prefix of the next marker
    function automatic logic [7:0] jpeg_start_byte(input logic [1:0] idx);
        logic [7:0] v;
        case (idx)
            2'd1:    v = 8'hD8;
            default: v = MARK_PREFIX;
        endcase
        return v;
    endfunction

endpackage

>>> src/ihds_cell.sv
`timescale 1ns / 1ps
// One byte cell of the sliding header window; cells chain toward the oldest byte.
// Depends on nothing but the clock; shift enable comes from the input handshake.
module ihds_cell (
    input  logic       i_clk,
    input  logic       i_shift,
    input  logic [7:0] i_byte,
    output logic [7:0] o_byte
);

    logic [7:0] r_byte;
    logic [7:0] n_byte;

    // Take the neighbor's byte on every accepted request, hold otherwise
    always_comb begin
        n_byte = i_shift ? i_byte : r_byte;
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

    assign o_byte = r_byte;

endmodule

>>> src/ihds_ctrl.sv
`timescale 1ns / 1ps
// Offset counter, signature flags and match logic of the header sniffer.
// Depends on ihds_pkg; reads the window taps of the cell chain.
module ihds_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    input  ihds_pkg::t_window i_window,
    output logic             o_push,
    output ihds_pkg::t_result o_result,
    output ihds_pkg::t_status o_status
);

    ihds_pkg::t_offset r_offset, n_offset;
    logic              r_png_ok, n_png_ok;
    logic              r_jpeg_ok, n_jpeg_ok;
    logic              r_reported, n_reported;

    logic png_hit;
    logic jpeg_hit;
    logic report;

    // Drop the signature flags on the first mismatching header byte
    always_comb begin
        n_png_ok  = r_png_ok;
        n_jpeg_ok = r_jpeg_ok;
        if (r_offset < ihds_pkg::t_offset'(ihds_pkg::PNG_SIG_LEN) &&
            i_byte != ihds_pkg::png_sig_byte(r_offset[2:0])) begin
            n_png_ok = 1'b0;
        end
        if (r_offset < ihds_pkg::t_offset'(ihds_pkg::JPEG_START_LEN) &&
            i_byte != ihds_pkg::jpeg_start_byte(r_offset[1:0])) begin
            n_jpeg_ok = 1'b0;
        end
    end

    // Match the PNG header end or a start-of-frame marker eight bytes back
    always_comb begin
        png_hit  = n_png_ok && r_offset == ihds_pkg::t_offset'(ihds_pkg::PNG_REPORT_POS);
        jpeg_hit = n_jpeg_ok
                && r_offset >= ihds_pkg::t_offset'(ihds_pkg::JPEG_FIRST_POS)
                && r_offset <= ihds_pkg::t_offset'(ihds_pkg::JPEG_LAST_POS)
                && i_window[0] == ihds_pkg::MARK_PREFIX
                && (i_window[1] inside {ihds_pkg::MARK_SOF0, ihds_pkg::MARK_SOF1,
                                        ihds_pkg::MARK_SOF2});
        report   = !r_reported && (png_hit || jpeg_hit || i_last);
    end

    // Build the report; unknown kind carries zero sizes
    always_comb begin
        o_result = '0;
        if (png_hit) begin
            o_result.kind   = ihds_pkg::KIND_PNG;
            o_result.width  = {i_window[1], i_window[2], i_window[3], i_window[4]};
            o_result.height = {i_window[5], i_window[6], i_window[7], i_byte};
        end else if (jpeg_hit) begin
            o_result.kind   = ihds_pkg::KIND_JPEG;
            o_result.height = {16'd0, i_window[5], i_window[6]};
            o_result.width  = {16'd0, i_window[7], i_byte};
        end else begin
            o_result.kind   = ihds_pkg::KIND_UNKNOWN;
        end
        o_push = i_accept && report;
    end

    // Advance the offset up to its cap; clear everything after the last byte
    always_comb begin
        n_offset   = r_offset;
        n_reported = r_reported;
        if (i_accept) begin
            if (i_last) begin
                n_offset   = '0;
                n_reported = 1'b0;
            end else begin
                if (r_offset < ihds_pkg::t_offset'(ihds_pkg::OFFSET_CAP)) begin
                    n_offset = r_offset + ihds_pkg::t_offset'(1);
                end
                n_reported = r_reported || report;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset   <= '0;
            r_png_ok   <= 1'b1;
            r_jpeg_ok  <= 1'b1;
            r_reported <= 1'b0;
        end else begin
            r_offset   <= n_offset;
            r_reported <= n_reported;
            if (i_accept) begin
                r_png_ok  <= i_last ? 1'b1 : n_png_ok;
                r_jpeg_ok <= i_last ? 1'b1 : n_jpeg_ok;
            end
        end
    end

    assign o_status.offset   = r_offset;
    assign o_status.reported = r_reported;

endmodule

>>> src/ihds_out.sv
`timescale 1ns / 1ps
// Output register with a skid stage for the sniffer's reports.
// Depends on ihds_pkg for the report type.
module ihds_out (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ihds_pkg::t_result i_result,
    input  logic              i_stall,
    output logic              o_valid,
    output ihds_pkg::t_result o_result,
    output logic              o_busy
);

    logic              r_out_valid;
    ihds_pkg::t_result r_out;
    logic              r_skid_valid;
    ihds_pkg::t_result r_skid;
    logic              out_free;

    assign out_free = !r_out_valid || !i_stall;

    // Control: refill the output from the skid first, else park a new report
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid || i_push;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Payload: no reset needed
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : i_result;
        end
        if (!out_free && i_push) begin
            r_skid <= i_result;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;
    assign o_busy   = r_skid_valid;

endmodule

>>> src/image_header_dimension_sniffer.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake            Payload
// -------  ---------  -------------------  -----------------------------------------
// bytes    in         i_valid / o_stall    i_data_byte[8], i_last_byte[1]
// report   out        o_valid / i_stall    o_image_kind[2], o_image_width[32],
//                                          o_image_height[32]
//
// One byte is taken per cycle while o_stall is low. At most one report per file; it is
// registered in the output register, or in the skid stage behind a stalled output.
// Reset (synchronous, i_rst_n low) clears the offset counter, flags and output stage.
// o_stall rises only when a report sits in the skid stage behind a stalled output;
// it depends on registers alone.
// Top level of the sniffer: instantiates the byte cell chain, ihds_ctrl and ihds_out.
module image_header_dimension_sniffer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_image_kind,
    output logic [31:0] o_image_width,
    output logic [31:0] o_image_height
);

    logic              w_accept;
    logic              w_busy;
    logic              w_push;
    ihds_pkg::t_window w_window;
    ihds_pkg::t_result w_result;
    ihds_pkg::t_result w_out;
    ihds_pkg::t_status w_status;

    assign w_accept = i_valid && !w_busy;
    assign o_stall  = w_busy;

    // Shift chain: the newest byte enters the top cell
    for (genvar k = 0; k < ihds_pkg::WINDOW_CELLS; k++) begin : g_cell
        logic [7:0] w_feed;
        if (k == ihds_pkg::WINDOW_CELLS - 1) begin : g_top
            assign w_feed = i_data_byte;
        end else begin : g_mid
            assign w_feed = w_window[k + 1];
        end
        ihds_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (w_accept),
            .i_byte  (w_feed),
            .o_byte  (w_window[k])
        );
    end

    ihds_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_byte   (i_data_byte),
        .i_last   (i_last_byte),
        .i_window (w_window),
        .o_push   (w_push),
        .o_result (w_result),
        .o_status (w_status)
    );

    ihds_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_result (w_result),
        .i_stall  (i_stall),
        .o_valid  (o_valid),
        .o_result (w_out),
        .o_busy   (w_busy)
    );

    assign o_image_kind   = w_out.kind;
    assign o_image_width  = w_out.width;
    assign o_image_height = w_out.height;

    // The offset counter never runs past its cap
    a_offset_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.offset <= ihds_pkg::t_offset'(ihds_pkg::OFFSET_CAP))
        else $error("offset counter past cap");

    // The last byte of a file leaves the sniffer ready for the next file
    a_file_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_last_byte |=> w_status.offset == '0 && !w_status.reported)
        else $error("state not cleared after last byte");

    // After a report is pushed into the output stage, o_valid is high on the next cycle
    a_push_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |=> o_valid)
        else $error("pushed report lost");

    // Upstream is held only while the output register is occupied
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("stall with empty output");

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for image_header_dimension_sniffer: streams PNG, JPEG and noise
// files with random idling on both sides and checks every dimension report.
// Depends on ihds_pkg and the sniffer RTL in src.
module tb_top;

    localparam int RANDOM_REQS = 1520;
    localparam int MAX_IDLE    = 20;
    localparam int DRAIN       = 20;
    localparam int SAT_POS     = (ihds_pkg::SCAN_LIMIT + 2 > 24) ?
                                 ihds_pkg::SCAN_LIMIT + 2 : 24;

    localparam logic [7:0] SOI_CODE = 8'hD8;
    localparam logic [7:0] MARK_DHT = 8'hC4;
    localparam logic [7:0] PNG_MAGIC [8] = '{8'h89, 8'h50, 8'h4E, 8'h47,
                                             8'h0D, 8'h0A, 8'h1A, 8'h0A};
    localparam logic [7:0] JPEG_SOI [3] = '{ihds_pkg::MARK_PREFIX, SOI_CODE,
                                            ihds_pkg::MARK_PREFIX};

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_byte_req;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_data_byte = '0;
    logic        i_last_byte = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_image_kind;
    logic [31:0] o_image_width;
    logic [31:0] o_image_height;

    image_header_dimension_sniffer uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_image_kind   (o_image_kind),
        .o_image_width  (o_image_width),
        .o_image_height (o_image_height)
    );

    always #5 i_clk = ~i_clk;

    t_byte_req         req_queue [$];
    logic [7:0]        file_buf [$];
    ihds_pkg::t_result expected_dims [$];

    int     accepted_cnt = 0;
    int     total_reqs = 0;
    int     file_cnt = 0;
    int     fail_cnt = 0;
    longint cycle_cnt = 0;
    longint cycle_limit = 64'h7FFF_FFFF_FFFF;

    // Sniffer state mirror
    int         seen_pos;
    logic [7:0] hdr_window [9];
    logic       png_magic_ok;
    logic       jpeg_soi_ok;
    logic       dims_sent;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        fail_cnt++;
    endtask

    task automatic clear_sniff_state();
        seen_pos     = 0;
        for (int k = 0; k < 9; k++) hdr_window[k] = '0;
        png_magic_ok = 1'b1;
        jpeg_soi_ok  = 1'b1;
        dims_sent    = 1'b0;
    endtask

    // Append one byte to the file under construction
    task automatic add_byte(input logic [7:0] b);
        file_buf.insert(file_buf.size(), b);
    endtask

    // Advance the mirror by one byte and queue the report it produces, if any
    task automatic sniff_byte(input logic [7:0] b, input logic last);
        ihds_pkg::t_result r;
        logic              hit;
        int                pos;
        pos = seen_pos;
        for (int k = 0; k < 8; k++) hdr_window[k] = hdr_window[k + 1];
        hdr_window[8] = b;
        if (pos < 8 && b != PNG_MAGIC[pos]) png_magic_ok = 1'b0;
        if (pos < 3 && b != JPEG_SOI[pos]) jpeg_soi_ok = 1'b0;

        hit      = 1'b0;
        r.kind   = ihds_pkg::KIND_UNKNOWN;
        r.width  = '0;
        r.height = '0;
        if (!dims_sent) begin
            if (png_magic_ok && pos == 23) begin
                hit      = 1'b1;
                r.kind   = ihds_pkg::KIND_PNG;
                r.width  = {hdr_window[1], hdr_window[2], hdr_window[3], hdr_window[4]};
                r.height = {hdr_window[5], hdr_window[6], hdr_window[7], hdr_window[8]};
            end else if (jpeg_soi_ok && pos >= 10 && pos <= ihds_pkg::SCAN_LIMIT + 1 &&
                         hdr_window[0] == ihds_pkg::MARK_PREFIX &&
                         (hdr_window[1] == ihds_pkg::MARK_SOF0 ||
                          hdr_window[1] == ihds_pkg::MARK_SOF1 ||
                          hdr_window[1] == ihds_pkg::MARK_SOF2)) begin
                hit      = 1'b1;
                r.kind   = ihds_pkg::KIND_JPEG;
                r.height = {16'h0, hdr_window[5], hdr_window[6]};
                r.width  = {16'h0, hdr_window[7], hdr_window[8]};
            end else if (last) begin
                hit = 1'b1;
            end
        end
        if (hit) begin
            dims_sent = 1'b1;
            expected_dims.insert(expected_dims.size(), r);
        end
        if (seen_pos < SAT_POS) seen_pos++;
        if (last) clear_sniff_state();
    endtask

    // File builders: each fills file_buf, emit_file turns it into requests
    task automatic push_be(input logic [31:0] v, input int nbytes);
        for (int k = nbytes - 1; k >= 0; k--) add_byte(v[8*k +: 8]);
    endtask

    task automatic png_file(input logic [31:0] w, input logic [31:0] h, input int tail);
        for (int k = 0; k < 8; k++) add_byte(PNG_MAGIC[k]);
        push_be(32'h0000_000D, 4);
        push_be(32'h4948_4452, 4);
        push_be(w, 4);
        push_be(h, 4);
        for (int k = 0; k < tail; k++) add_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic jpeg_file(input int mpos, input logic [7:0] code, input logic [15:0] h,
                             input logic [15:0] w, input int tail, input logic dirty);
        for (int k = 0; k < 3; k++) add_byte(JPEG_SOI[k]);
        // filler before the frame marker; a dirty file may hold early markers
        for (int k = 3; k < mpos; k++)
            add_byte(8'($urandom_range(0, dirty ? 255 : 254)));
        if (mpos > 2) add_byte(ihds_pkg::MARK_PREFIX);
        add_byte(code);
        push_be(32'd17, 2);
        add_byte(8'h08);
        push_be({16'h0, h}, 2);
        push_be({16'h0, w}, 2);
        for (int k = 0; k < tail; k++) add_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic noise_file(input int len);
        int roll;
        roll = $urandom_range(0, 3);
        if (roll == 0) add_byte(PNG_MAGIC[0]);
        else if (roll == 1) add_byte(ihds_pkg::MARK_PREFIX);
        while (file_buf.size() < len) add_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic emit_file(input int spoil_idx, input int cut);
        t_byte_req r;
        if (spoil_idx >= 0 && spoil_idx < file_buf.size())
            file_buf[spoil_idx] = file_buf[spoil_idx] ^ 8'($urandom_range(1, 255));
        if (cut > 0)
            while (file_buf.size() > cut) file_buf.delete(file_buf.size() - 1);
        for (int k = 0; k < file_buf.size(); k++) begin
            r.data = file_buf[k];
            r.last = (k == file_buf.size() - 1);
            req_queue.insert(req_queue.size(), r);
        end
        file_buf.delete();
        file_cnt++;
    endtask

    function automatic logic [31:0] pick_dim(input int nbytes);
        logic [31:0] v;
        int          roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) v = '0;
        else if (roll == 1) v = '1;
        else v = $urandom;
        if (nbytes == 2) v[31:16] = '0;
        return v;
    endfunction

    function automatic logic [7:0] pick_sof();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return MARK_DHT;
        if (roll < 4) return ihds_pkg::MARK_SOF0;
        if (roll < 7) return ihds_pkg::MARK_SOF1;
        return ihds_pkg::MARK_SOF2;
    endfunction

    // Mostly no idle, some short idles, a few long ones
    function automatic int pick_idle();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(8, MAX_IDLE);
    endfunction

    // Request driver: hold a stalled request, else idle or present the next one
    int        gap_left = 0;
    int        calm_in = 0;
    t_byte_req cur_req;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (gap_left > 0) begin
                i_valid  <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (req_queue.size() > 0) begin
                cur_req = req_queue.pop_front();
                i_data_byte <= cur_req.data;
                i_last_byte <= cur_req.last;
                i_valid     <= 1'b1;
                if (calm_in > 0) begin
                    calm_in  <= calm_in - 1;
                    gap_left <= 0;
                end else begin
                    gap_left <= pick_idle();
                    calm_in  <= ($urandom_range(0, 149) == 0) ? 200 : 0;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Report sink: random stall bursts with occasional calm stretches
    int stall_left = 0;
    int calm_out = 0;

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_stall    <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (calm_out > 0) begin
            i_stall  <= 1'b0;
            calm_out <= calm_out - 1;
        end else begin
            i_stall    <= 1'b0;
            stall_left <= pick_idle();
            calm_out   <= ($urandom_range(0, 299) == 0) ? 400 : 0;
        end
    end

    // Monitor: predict on each accepted request, then check each accepted report
    ihds_pkg::t_result exp_r;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                sniff_byte(i_data_byte, i_last_byte);
                accepted_cnt++;
            end
            if (o_valid && !i_stall) begin
                if (expected_dims.size() == 0) begin
                    report_mismatch($sformatf("unexpected report kind %0d w %0d h %0d",
                                              o_image_kind, o_image_width, o_image_height));
                end else begin
                    exp_r = expected_dims.pop_front();
                    if (o_image_kind !== exp_r.kind)
                        report_mismatch($sformatf("kind got %0d want %0d",
                                                  o_image_kind, exp_r.kind));
                    if (o_image_width !== exp_r.width)
                        report_mismatch($sformatf("width got %0h want %0h",
                                                  o_image_width, exp_r.width));
                    if (o_image_height !== exp_r.height)
                        report_mismatch($sformatf("height got %0h want %0h",
                                                  o_image_height, exp_r.height));
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > cycle_limit) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        int roll;
        int n0;
        int mpos;
        int cut;
        int spoil;

        clear_sniff_state();

        // Directed files
        png_file('1, '1, 0);                           // report on the last byte
        emit_file(-1, 0);
        png_file('0, '0, 3);                           // bytes after a report
        emit_file(-1, 0);
        png_file(32'h0001_0000, 32'h8000_0001, 0);     // short PNG
        emit_file(-1, 23);
        jpeg_file(2, ihds_pkg::MARK_SOF0, 16'hFFFF, 16'h0000, 0, 1'b0);
        emit_file(-1, 0);
        jpeg_file(5, ihds_pkg::MARK_SOF1, 16'h0000, 16'hFFFF, 2, 1'b0);
        emit_file(-1, 0);
        jpeg_file(4, ihds_pkg::MARK_SOF2, 16'hA5A5, 16'h5A5A, 1, 1'b0);
        emit_file(-1, 0);
        jpeg_file(6, ihds_pkg::MARK_SOF0, 16'h0102, 16'h0304, 0, 1'b0);  // cut before +8
        emit_file(-1, 13);
        add_byte(ihds_pkg::MARK_PREFIX);               // one-byte file
        emit_file(-1, 0);

        // Random files, mostly well formed
        n0 = req_queue.size();
        while (req_queue.size() - n0 < RANDOM_REQS) begin
            roll  = $urandom_range(0, 99);
            spoil = -1;
            cut   = 0;
            if (roll < 35) begin
                png_file(pick_dim(4), pick_dim(4), $urandom_range(0, 12));
                if ($urandom_range(0, 6) == 0) spoil = $urandom_range(0, 7);
                if ($urandom_range(0, 6) == 0) cut = $urandom_range(1, 23);
            end else if (roll < 75) begin
                mpos = $urandom_range(2, 30);
                jpeg_file(mpos, pick_sof(), 16'(pick_dim(2)), 16'(pick_dim(2)),
                          $urandom_range(0, 12), $urandom_range(0, 4) == 0);
                if ($urandom_range(0, 9) == 0) spoil = $urandom_range(0, 2);
                if ($urandom_range(0, 9) == 0) cut = $urandom_range(1, mpos + 8);
            end else begin
                noise_file($urandom_range(1, 40));
            end
            emit_file(spoil, cut);
        end

        total_reqs  = req_queue.size();
        cycle_limit = 4 * (longint'(total_reqs) * (MAX_IDLE + 2) +
                           longint'(file_cnt) * (MAX_IDLE + 2) + 2000);

        // Hold reset, then release it
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_cnt < total_reqs) @(posedge i_clk);
        while (expected_dims.size() > 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        if (expected_dims.size() > 0)
            report_mismatch($sformatf("%0d reports never arrived", expected_dims.size()));
        if (fail_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
